[src/btb_pkg.sv]
`timescale 1ns / 1ps
package btb_pkg;

	localparam int unsigned RANK_W  = 10;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned EVENT_W = 16;
	localparam int unsigned STEP_W  = 4;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;

	// largest rank count the tree supports
	localparam int unsigned MAX_RANKS  = 1024;
	localparam int unsigned RANK_LIMIT = (MAX_RANKS < 1024) ? MAX_RANKS : 1024;
	localparam logic [COUNT_W-1:0] RANK_LIMIT_C = COUNT_W'(RANK_LIMIT);

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MY_RANK      = 2'd0;
	localparam logic [1:0] REG_TOTAL_RANKS  = 2'd1;
	localparam logic [1:0] REG_LOCAL_EVENTS = 2'd2;

	localparam logic REQ_EVENT   = 1'b0;
	localparam logic KIND_SEND   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_SOURCE    = 3'd1,
		ERR_EVENT     = 3'd2,
		ERR_REPORT    = 3'd3,
		ERR_PREMATURE = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_SELF,
		ST_PARENT,
		ST_STATUS
	} state_t;

	typedef struct packed {
		logic [RANK_W-1:0]  my_rank;
		logic [COUNT_W-1:0] total_ranks;
		logic [EVENT_W-1:0] local_events;
	} cfg_t;

	typedef struct packed {
		logic wr;
		cfg_t regs;
	} cfg_bus_t;

	function automatic logic [COUNT_W-1:0] rank_count(input logic [COUNT_W-1:0] total);
		logic [COUNT_W-1:0] n;
		n = total;
		if (n == '0) n = COUNT_W'(1);
		if (n > RANK_LIMIT_C) n = RANK_LIMIT_C;
		return n;
	endfunction

	// clear lowest set bit
	function automatic logic [RANK_W-1:0] parent_of(input logic [RANK_W-1:0] r);
		return r & (r - RANK_W'(1));
	endfunction

endpackage

[src/binomial_tree_barrier_node.sv]
`timescale 1ns / 1ps
// One node of a binomial-tree barrier. Program my_rank, total_ranks and
// local_events over APB; a write to any of these registers restarts the node as a reset does.
// A req item is either a local event (req_type 0) or an arriving barrier
// message tagged with its sender (req_type 1). Each item yields one status
// result (kind 1, with an error code) or 1 to 11 sends (kind 0) toward the
// parent, the children, or, at the root, itself; last marks the final result.
// One item at a time: an item occupies the node until the last of the results it
// causes (1..11) has entered the output register, and req_stall stays high meanwhile.
// The child sends come out of one shared rank adder that steps through the children
// one per cycle while the result side is not stalling. After reset or such a write
// the same adder walks the tree to count the children; req_stall is held high during
// that walk.
module binomial_tree_barrier_node (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btb_pkg::ADDR_W-1:0]  paddr,
	input  logic [btb_pkg::DATA_W-1:0]  pwdata,
	output logic [btb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        req_type,
	input  logic [btb_pkg::RANK_W-1:0]  source_rank,
	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        kind,
	output logic [btb_pkg::RANK_W-1:0]  dest_rank,
	output logic                        done_res,
	output logic [2:0]                  error,
	output logic                        last
);

	btb_pkg::cfg_bus_t cfg_bus;

	btb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg_bus)
	);

	logic [btb_pkg::RANK_W-1:0]  my_rank;
	logic [btb_pkg::COUNT_W-1:0] n_ranks;
	logic [btb_pkg::EVENT_W-1:0] ev_init;

	assign my_rank = cfg_bus.regs.my_rank;
	assign n_ranks = btb_pkg::rank_count(cfg_bus.regs.total_ranks);
	// zero local events behaves as one
	assign ev_init = (cfg_bus.regs.local_events == '0) ? btb_pkg::EVENT_W'(1)
		: cfg_bus.regs.local_events;

	// control state
	btb_pkg::state_t             state_q, state_d;
	logic [btb_pkg::STEP_W-1:0]  pending_q;
	logic                        started_q;
	logic                        finished_q;
	logic [btb_pkg::EVENT_W-1:0] events_left_q;
	logic [btb_pkg::STEP_W-1:0]  child_cnt_q;
	logic [btb_pkg::STEP_W-1:0]  idx_q;
	logic                        self_q;
	btb_pkg::err_t               err_q;

	// captured item
	logic                        req_type_q;
	logic [btb_pkg::RANK_W-1:0]  source_rank_q;

	// output register
	logic                        res_valid_q;
	logic                        kind_q;
	logic [btb_pkg::RANK_W-1:0]  dest_q;
	logic                        done_q;
	btb_pkg::err_t               err_out_q;
	logic                        last_q;

	// shared rank adder: my_rank + 2^idx, tested against the tree shape
	logic [btb_pkg::COUNT_W-1:0] step_j;
	logic [btb_pkg::COUNT_W-1:0] step_sum;
	logic                        walk_ok;
	logic                        walk_last;
	logic                        slot_free;

	assign step_j    = btb_pkg::COUNT_W'(1) << idx_q;
	assign step_sum  = btb_pkg::COUNT_W'(my_rank) + step_j;
	assign walk_ok   = (step_j != '0) && ((step_j & btb_pkg::COUNT_W'(my_rank)) == '0)
		&& (step_sum < n_ranks);
	assign walk_last = (idx_q == (child_cnt_q - btb_pkg::STEP_W'(1)));
	assign slot_free = !res_valid_q || !res_stall;

	// decision for the captured item
	logic [btb_pkg::EVENT_W-1:0] ev_cur, ev_dec;
	logic                        is_parent, is_child, is_root_self;
	btb_pkg::state_t             dec_state;
	btb_pkg::err_t               dec_err;
	logic                        dec_event, dec_start, dec_report, dec_complete, dec_self;
	logic                        do_report;

	assign ev_cur       = (events_left_q == '0) ? btb_pkg::EVENT_W'(1) : events_left_q;
	assign ev_dec       = ev_cur - btb_pkg::EVENT_W'(1);
	assign is_parent    = (my_rank != '0) && (source_rank_q == btb_pkg::parent_of(my_rank));
	assign is_child     = (source_rank_q != '0)
		&& (btb_pkg::parent_of(source_rank_q) == my_rank);
	assign is_root_self = (my_rank == '0) && (source_rank_q == '0);

	always_comb begin
		dec_state    = btb_pkg::ST_STATUS;
		dec_err      = btb_pkg::ERR_OK;
		dec_event    = 1'b0;
		dec_start    = 1'b0;
		dec_report   = 1'b0;
		dec_complete = 1'b0;
		dec_self     = 1'b0;
		do_report    = 1'b0;
		if (req_type_q == btb_pkg::REQ_EVENT) begin
			if (started_q || finished_q) begin
				dec_err = btb_pkg::ERR_EVENT;
			end else begin
				dec_event = 1'b1;
				if (ev_dec == '0) begin
					dec_start = 1'b1;
					do_report = 1'b1;
				end
			end
		end else if (is_parent) begin
			if (started_q && (pending_q == '0) && !finished_q) begin
				dec_complete = 1'b1;
				dec_state    = (child_cnt_q != '0) ? btb_pkg::ST_WALK : btb_pkg::ST_STATUS;
			end else begin
				dec_err = btb_pkg::ERR_PREMATURE;
			end
		end else if (is_child) begin
			do_report = 1'b1;
		end else if (!is_root_self) begin
			dec_err = btb_pkg::ERR_SOURCE;
		end

		// own report or a child's report
		if (do_report) begin
			if (finished_q || (pending_q == '0)
					|| ((pending_q == btb_pkg::STEP_W'(1)) && !(started_q || dec_start))) begin
				dec_err = btb_pkg::ERR_REPORT;
			end else begin
				dec_report = 1'b1;
				if (pending_q == btb_pkg::STEP_W'(1)) begin
					if (my_rank == '0) begin
						// root: complete, fan out, then message to itself
						dec_complete = 1'b1;
						dec_self     = 1'b1;
						dec_state    = (child_cnt_q != '0) ? btb_pkg::ST_WALK
							: btb_pkg::ST_SELF;
					end else begin
						dec_state = btb_pkg::ST_PARENT;
					end
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			btb_pkg::ST_INIT:   if (!walk_ok) state_d = btb_pkg::ST_IDLE;
			btb_pkg::ST_IDLE:   if (req_valid) state_d = btb_pkg::ST_DECIDE;
			btb_pkg::ST_DECIDE: state_d = dec_state;
			btb_pkg::ST_WALK: begin
				if (slot_free && walk_last)
					state_d = self_q ? btb_pkg::ST_SELF : btb_pkg::ST_IDLE;
			end
			btb_pkg::ST_SELF, btb_pkg::ST_PARENT, btb_pkg::ST_STATUS: begin
				if (slot_free) state_d = btb_pkg::ST_IDLE;
			end
			default: state_d = btb_pkg::ST_INIT;
		endcase
		if (cfg_bus.wr) state_d = btb_pkg::ST_INIT;
	end

	// emission into the output register
	logic                        emit;
	logic                        e_kind;
	logic [btb_pkg::RANK_W-1:0]  e_dest;
	btb_pkg::err_t               e_err;
	logic                        e_last;

	always_comb begin
		emit   = 1'b0;
		e_kind = btb_pkg::KIND_SEND;
		e_dest = '0;
		e_err  = btb_pkg::ERR_OK;
		e_last = 1'b0;
		unique case (state_q) inside
			btb_pkg::ST_WALK: begin
				emit   = slot_free;
				e_dest = step_sum[btb_pkg::RANK_W-1:0];
				e_last = walk_last && !self_q;
			end
			btb_pkg::ST_SELF: begin
				emit   = slot_free;
				e_last = 1'b1;
			end
			btb_pkg::ST_PARENT: begin
				emit   = slot_free;
				e_dest = btb_pkg::parent_of(my_rank);
				e_last = 1'b1;
			end
			btb_pkg::ST_STATUS: begin
				emit   = slot_free;
				e_kind = btb_pkg::KIND_STATUS;
				e_err  = err_q;
				e_last = 1'b1;
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != btb_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= btb_pkg::ST_INIT;
			pending_q     <= btb_pkg::STEP_W'(1);
			started_q     <= 1'b0;
			finished_q    <= 1'b0;
			events_left_q <= btb_pkg::EVENT_W'(1);
			child_cnt_q   <= '0;
			idx_q         <= '0;
			self_q        <= 1'b0;
			err_q         <= btb_pkg::ERR_OK;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;

			if (cfg_bus.wr) begin
				// restart the child-count walk with the new registers
				idx_q       <= '0;
				child_cnt_q <= '0;
			end else begin
				unique case (state_q) inside
					btb_pkg::ST_INIT: begin
						started_q     <= 1'b0;
						finished_q    <= 1'b0;
						self_q        <= 1'b0;
						events_left_q <= ev_init;
						if (walk_ok) begin
							child_cnt_q <= child_cnt_q + btb_pkg::STEP_W'(1);
							idx_q       <= idx_q + btb_pkg::STEP_W'(1);
						end else begin
							pending_q <= child_cnt_q + btb_pkg::STEP_W'(1);
							idx_q     <= '0;
						end
					end
					btb_pkg::ST_DECIDE: begin
						if (dec_event) events_left_q <= ev_dec;
						if (dec_start) started_q <= 1'b1;
						if (dec_report) pending_q <= pending_q - btb_pkg::STEP_W'(1);
						if (dec_complete) finished_q <= 1'b1;
						self_q <= dec_self;
						err_q  <= dec_err;
						idx_q  <= '0;
					end
					btb_pkg::ST_WALK: begin
						if (slot_free) idx_q <= idx_q + btb_pkg::STEP_W'(1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == btb_pkg::ST_IDLE) && req_valid) begin
			req_type_q    <= req_type;
			source_rank_q <= source_rank;
		end
		if (emit) begin
			kind_q    <= e_kind;
			dest_q    <= e_dest;
			done_q    <= finished_q;
			err_out_q <= e_err;
			last_q    <= e_last;
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign dest_rank = dest_q;
	assign done_res  = done_q;
	assign error     = err_out_q;
	assign last      = last_q;

endmodule

[src/btb_cfg.sv]
`timescale 1ns / 1ps
module btb_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btb_pkg::ADDR_W-1:0]  paddr,
	input  logic [btb_pkg::DATA_W-1:0]  pwdata,
	output logic [btb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output btb_pkg::cfg_bus_t           cfg
);

	btb_pkg::cfg_t cfg_q;
	logic [1:0]    idx;
	logic          wr_en;
	logic          wr_hit;

	assign idx    = paddr[btb_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_comb begin
		wr_hit = 1'b0;
		prdata = '0;
		unique case (idx)
			btb_pkg::REG_MY_RANK: begin
				wr_hit = wr_en;
				prdata = btb_pkg::DATA_W'(cfg_q.my_rank);
			end
			btb_pkg::REG_TOTAL_RANKS: begin
				wr_hit = wr_en;
				prdata = btb_pkg::DATA_W'(cfg_q.total_ranks);
			end
			btb_pkg::REG_LOCAL_EVENTS: begin
				wr_hit = wr_en;
				prdata = btb_pkg::DATA_W'(cfg_q.local_events);
			end
			default: begin
				wr_hit = 1'b0;
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.my_rank      <= '0;
			cfg_q.total_ranks  <= btb_pkg::COUNT_W'(1);
			cfg_q.local_events <= btb_pkg::EVENT_W'(1);
		end else if (wr_en) begin
			unique case (idx)
				btb_pkg::REG_MY_RANK:
					cfg_q.my_rank <= pwdata[btb_pkg::RANK_W-1:0];
				btb_pkg::REG_TOTAL_RANKS:
					cfg_q.total_ranks <= pwdata[btb_pkg::COUNT_W-1:0];
				btb_pkg::REG_LOCAL_EVENTS:
					cfg_q.local_events <= pwdata[btb_pkg::EVENT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.wr   = wr_hit;
	assign cfg.regs = cfg_q;

endmodule

[src/btb_checker.sv]
`timescale 1ns / 1ps
module btb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic                        kind,
	input logic [btb_pkg::RANK_W-1:0]  dest_rank,
	input logic                        done_res,
	input logic [2:0]                  error,
	input logic                        last
);

	// stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable({kind, dest_rank, done_res, error, last}))
		else $error("stalled result item changed");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item accepted while previous one in flight");

	a_send_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == btb_pkg::KIND_SEND) |-> (error == btb_pkg::ERR_OK))
		else $error("send item carries an error code");

	// a status item is always the final result of its item and has no destination
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == btb_pkg::KIND_STATUS) |-> last && (dest_rank == '0))
		else $error("status item not final or has a destination");

endmodule

bind binomial_tree_barrier_node btb_checker u_btb_checker (.*);

[bench/barrier_node_checker.sv]
`timescale 1ns / 1ps
module barrier_node_checker
	import btb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic                req_type,
	input  logic [RANK_W-1:0]   source_rank,
	input  logic                res_valid,
	input  logic                res_stall,
	input  logic                kind,
	input  logic [RANK_W-1:0]   dest_rank,
	input  logic                done_res,
	input  logic [2:0]          error,
	input  logic                last,
	output int                  outstanding,
	output int                  fail_count,
	output int                  results_checked,
	output logic [4:0]          codes_seen
);

	localparam int RANK_CAP = (MAX_RANKS < 1024) ? MAX_RANKS : 1024;

	typedef struct packed {
		logic              kind;
		logic [RANK_W-1:0] dest;
		logic              done;
		err_t              err;
		logic              last;
	} barrier_res_t;

	barrier_res_t due_results[$];
	barrier_res_t step_results[$];

	// programmed registers
	logic [RANK_W-1:0]  node_rank;
	logic [COUNT_W-1:0] rank_total;
	logic [EVENT_W-1:0] event_target;

	// node state
	int unsigned        reports_owed;
	logic               is_started;
	logic               is_finished;
	logic [EVENT_W-1:0] events_owed;

	int                 n_fail;
	int                 n_checked;
	logic [4:0]         n_codes;

	function automatic int live_ranks();
		int n;
		n = int'(rank_total);
		if (n == 0) n = 1;
		if (n > RANK_CAP) n = RANK_CAP;
		return n;
	endfunction

	function automatic logic [RANK_W-1:0] parent_rank(input logic [RANK_W-1:0] r);
		logic [RANK_W-1:0] low_bit;
		low_bit = r & (~r + 1'b1);
		return r ^ low_bit;
	endfunction

	function automatic void restart_node();
		int kids;
		int n;
		kids = 0;
		n = live_ranks();
		for (int j = 1; j < 2048 && int'(node_rank) + j < n && (int'(node_rank) & j) == 0;
				j = j << 1)
			kids++;
		reports_owed = kids + 1;
		is_started = 1'b0;
		is_finished = 1'b0;
		events_owed = (event_target == '0) ? EVENT_W'(1) : event_target;
	endfunction

	function automatic barrier_res_t res_item(input logic k, input logic [RANK_W-1:0] d,
			input err_t e);
		barrier_res_t r;
		r.kind = k;
		r.dest = d;
		r.done = is_finished;
		r.err  = e;
		r.last = 1'b0;
		return r;
	endfunction

	// completion: finished, then one send per child
	function automatic void fan_out_children();
		int n;
		n = live_ranks();
		is_finished = 1'b1;
		for (int j = 1; j < 2048 && int'(node_rank) + j < n && (int'(node_rank) & j) == 0;
				j = j << 1)
			step_results.push_back(res_item(KIND_SEND, RANK_W'(int'(node_rank) + j), ERR_OK));
	endfunction

	function automatic err_t absorb_report();
		if (is_finished || reports_owed == 0 || (reports_owed == 1 && !is_started))
			return ERR_REPORT;
		reports_owed--;
		if (reports_owed == 0) begin
			if (node_rank == '0) begin
				fan_out_children();
				step_results.push_back(res_item(KIND_SEND, '0, ERR_OK));
			end else begin
				step_results.push_back(res_item(KIND_SEND, parent_rank(node_rank), ERR_OK));
			end
		end
		return ERR_OK;
	endfunction

	function automatic void predict_barrier_step(input logic rtype,
			input logic [RANK_W-1:0] src);
		err_t code;
		code = ERR_OK;
		step_results.delete();
		if (rtype == REQ_EVENT) begin
			if (is_started || is_finished) begin
				code = ERR_EVENT;
			end else begin
				if (events_owed == '0) events_owed = EVENT_W'(1);
				events_owed = events_owed - 1'b1;
				if (events_owed == '0) begin
					is_started = 1'b1;
					code = absorb_report();
				end
			end
		end else if (node_rank != '0 && src == parent_rank(node_rank)) begin
			if (is_started && reports_owed == 0 && !is_finished)
				fan_out_children();
			else
				code = ERR_PREMATURE;
		end else if (src != '0 && parent_rank(src) == node_rank) begin
			code = absorb_report();
		end else if (!(node_rank == '0 && src == '0)) begin
			code = ERR_SOURCE;
		end
		if (step_results.size() == 0) begin
			step_results.push_back(res_item(KIND_STATUS, '0, code));
			n_codes[code] = 1'b1;
		end
		step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i]) due_results.push_back(step_results[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		barrier_res_t want;
		if (!arst_n) begin
			node_rank = '0;
			rank_total = COUNT_W'(1);
			event_target = EVENT_W'(1);
			restart_node();
			due_results.delete();
			n_fail = 0;
			n_checked = 0;
			n_codes = '0;
		end else begin
			// register write: reload and restart
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MY_RANK:      node_rank = pwdata[RANK_W-1:0];
					REG_TOTAL_RANKS:  rank_total = pwdata[COUNT_W-1:0];
					REG_LOCAL_EVENTS: event_target = pwdata[EVENT_W-1:0];
					default: ;
				endcase
				if (paddr[3:2] != 2'd3) restart_node();
			end
			if (res_valid && !res_stall) begin
				n_checked++;
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d dest %0d done %0d error %0d last %0d",
						kind, dest_rank, done_res, error, last);
					n_fail++;
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						n_fail++;
					end
					if (dest_rank !== want.dest) begin
						$error("dest_rank: expected %0d, got %0d", want.dest, dest_rank);
						n_fail++;
					end
					if (done_res !== want.done) begin
						$error("done_res: expected %0d, got %0d", want.done, done_res);
						n_fail++;
					end
					if (error !== want.err) begin
						$error("error: expected %0d, got %0d", want.err, error);
						n_fail++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						n_fail++;
					end
				end
			end
			if (req_valid && !req_stall)
				predict_barrier_step(req_type, source_rank);
		end
		outstanding     <= due_results.size();
		fail_count      <= n_fail;
		results_checked <= n_checked;
		codes_seen      <= n_codes;
	end

endmodule

[bench/tb_binomial_tree_barrier_node.sv]
`timescale 1ns / 1ps
module tb_binomial_tree_barrier_node;
	import btb_pkg::*;

	localparam int   ITEM_GOAL   = 470;
	localparam logic REQ_MESSAGE = 1'b1;

	typedef struct packed {
		logic              rtype;
		logic [RANK_W-1:0] src;
	} barrier_req_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                req_valid;
	logic                req_stall;
	logic                req_type;
	logic [RANK_W-1:0]   source_rank;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic                kind;
	logic [RANK_W-1:0]   dest_rank;
	logic                done_res;
	logic [2:0]          error;
	logic                last;

	int                  outstanding;
	int                  fail_count;
	int                  results_checked;
	logic [4:0]          codes_seen;

	int                  items_sent = 0;
	int                  settings_run = 0;
	logic                idle_on = 1'b1;
	int                  stall_left = 0;

	// the barrier sequence being built for the current setting
	barrier_req_t        plan_q[$];
	logic [RANK_W-1:0]   child_ranks[$];
	logic [RANK_W-1:0]   node_rank_v;

	binomial_tree_barrier_node uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.source_rank (source_rank),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.kind        (kind),
		.dest_rank   (dest_rank),
		.done_res    (done_res),
		.error       (error),
		.last        (last)
	);

	// predicts every item and compares the results
	barrier_node_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.source_rank     (source_rank),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.kind            (kind),
		.dest_rank       (dest_rank),
		.done_res        (done_res),
		.error           (error),
		.last            (last),
		.outstanding     (outstanding),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.codes_seen      (codes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stall bursts, none once idling is off
	always @(posedge clk) begin
		if (!idle_on) begin
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			res_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// setup cycle then access cycle; psel stays up so writes can go back to back
	task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// every write restarts the node, so all three go in together
	task automatic set_config(input logic [RANK_W-1:0] rank, input logic [COUNT_W-1:0] total,
			input logic [EVENT_W-1:0] events);
		apb_write(REG_MY_RANK, DATA_W'(rank));
		apb_write(REG_TOTAL_RANKS, DATA_W'(total));
		apb_write(REG_LOCAL_EVENTS, DATA_W'(events));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_run++;
	endtask

	// one item; returns at the edge where it was taken
	task automatic push_request(input logic rtype, input logic [RANK_W-1:0] src);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= rtype;
		source_rank <= src;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	// send the whole plan, then hold off until every result is back
	task automatic run_plan();
		barrier_req_t next_req;
		while (plan_q.size() != 0) begin
			next_req = plan_q.pop_front();
			push_request(next_req.rtype, next_req.src);
		end
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// misuse and stray traffic around the current node
	function automatic barrier_req_t noise_req();
		barrier_req_t r;
		r.rtype = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0: r.src = node_rank_v & (node_rank_v - 1'b1);
			1: r.src = (child_ranks.size() != 0) ?
				child_ranks[$urandom_range(0, child_ranks.size() - 1)] : node_rank_v;
			2: r.src = '0;
			default: r.src = RANK_W'($urandom_range(0, 1023));
		endcase
		return r;
	endfunction

	initial begin
		logic [COUNT_W-1:0] total_v;
		logic [EVENT_W-1:0] events_v;
		logic [RANK_W-1:0]  swap_rank;
		int                 n;
		int                 ev;
		int                 p;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		req_valid   = 1'b0;
		req_type    = REQ_EVENT;
		source_rank = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting, lone root: self message, stranger, start, late event, late report
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(0)});
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(1023)});
		plan_q.push_back('{REQ_EVENT, RANK_W'(0)});
		plan_q.push_back('{REQ_EVENT, RANK_W'(1023)});
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(1)});
		run_plan();

		// full tree root: ten children, duplicate report before start, then the
		// start that completes with the widest fanout
		set_config(RANK_W'(0), COUNT_W'(1024), EVENT_W'(2));
		plan_q.push_back('{REQ_EVENT, RANK_W'(0)});
		for (int j = 1; j < 1024; j = j << 1)
			plan_q.push_back('{REQ_MESSAGE, RANK_W'(j)});
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(1)});
		plan_q.push_back('{REQ_EVENT, RANK_W'(0)});
		run_plan();

		// leaf with clamped count and zero events: early parent, start, completion,
		// parent again after done, stranger
		set_config(RANK_W'(5), COUNT_W'(2047), EVENT_W'(0));
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(4)});
		plan_q.push_back('{REQ_EVENT, RANK_W'(0)});
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(4)});
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(4)});
		plan_q.push_back('{REQ_MESSAGE, RANK_W'(0)});
		run_plan();

		// random settings, each running one barrier with noise mixed in
		while (items_sent < ITEM_GOAL) begin
			if (items_sent > ITEM_GOAL * 4 / 5) idle_on <= 1'b0;
			case ($urandom_range(0, 7))
				0: total_v = '0;
				1: total_v = COUNT_W'(1);
				2: total_v = COUNT_W'(1024);
				3: total_v = COUNT_W'(2047);
				4: total_v = COUNT_W'($urandom_range(1, 2047));
				default: total_v = COUNT_W'($urandom_range(2, 64));
			endcase
			n = (total_v == '0) ? 1 : ((total_v > 1024) ? 1024 : int'(total_v));
			case ($urandom_range(0, 5))
				0: node_rank_v = '0;
				1: node_rank_v = RANK_W'(1023);
				2: node_rank_v = RANK_W'($urandom_range(0, 1023));
				default: node_rank_v = RANK_W'($urandom_range(0, n - 1));
			endcase
			case ($urandom_range(0, 9))
				0: events_v = '0;
				1: events_v = EVENT_W'(65535);
				default: events_v = EVENT_W'($urandom_range(1, 3));
			endcase
			// a huge event count never starts; just poke it a few times
			ev = (events_v == '0) ? 1 : int'(events_v);
			if (ev > 8) ev = $urandom_range(1, 4);

			child_ranks.delete();
			for (int j = 1; j < 2048 && int'(node_rank_v) + j < n &&
					(int'(node_rank_v) & j) == 0; j = j << 1)
				child_ranks.push_back(RANK_W'(int'(node_rank_v) + j));
			for (int i = child_ranks.size() - 1; i > 0; i--) begin
				p = $urandom_range(0, i);
				swap_rank = child_ranks[i];
				child_ranks[i] = child_ranks[p];
				child_ranks[p] = swap_rank;
			end
			// start lands before the last child report, except now and then
			p = (child_ranks.size() == 0) ? 0 : $urandom_range(0, child_ranks.size() - 1);
			if ($urandom_range(0, 9) == 0) p = child_ranks.size();

			set_config(node_rank_v, total_v, events_v);
			for (int i = 0; i <= child_ranks.size(); i++) begin
				if ($urandom_range(0, 7) == 0) plan_q.push_back(noise_req());
				if (i == p)
					repeat (ev) plan_q.push_back('{REQ_EVENT, RANK_W'($urandom_range(0, 1023))});
				if (i < child_ranks.size())
					plan_q.push_back('{REQ_MESSAGE, child_ranks[i]});
			end
			if (node_rank_v != '0 && $urandom_range(0, 9) != 0)
				plan_q.push_back('{REQ_MESSAGE, node_rank_v & (node_rank_v - 1'b1)});
			repeat ($urandom_range(0, 2)) plan_q.push_back(noise_req());
			run_plan();
		end

		repeat (20) @(posedge clk);
		$display("Ran %0d request items across %0d register settings; %0d results compared.",
			items_sent, settings_run, results_checked);
		$display("Status codes hit (one bit per code, ok in bit 0): %b", codes_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("[binomial_tree_barrier_node] OK");
		end else begin
			$display("[binomial_tree_barrier_node] ERROR");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#1000000;
		$display("[binomial_tree_barrier_node] ERROR");
		$finish;
	end

endmodule

[sim.f]
src/btb_pkg.sv
src/btb_cfg.sv
src/binomial_tree_barrier_node.sv
src/btb_checker.sv
bench/barrier_node_checker.sv
bench/tb_binomial_tree_barrier_node.sv
